// File: src/jccn_pkg.sv
// Shared constants and codes for the joystick calibration and normalization core
`default_nettype none

package jccn_pkg;

    localparam int CALIB_SAMPLES_DEF = 5;
    localparam int SAMPLE_BITS_DEF   = 14;

    localparam int NUM_AXES   = 4;
    localparam int AXIS_IDX_W = 2;
    localparam int OFF_W      = 14;
    localparam int THR_W      = 15;
    localparam int AXIS_W     = 16;
    localparam int WIN_W      = 18;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Normalization: raw * 2^NORM_SHIFT / offset - NORM_BIAS
    localparam int NORM_SHIFT = 9;
    localparam int NORM_BIAS  = 512;
    // Largest quotient that still fits after the bias is removed
    localparam int SAT_Q_MAX  = 33279;

    localparam logic [OFF_W-1:0]  CENTER_RESET    = 14'd5000;
    localparam logic [OFF_W-1:0]  WINDOW_RESET    = 14'd1000;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 15'd10;
    localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_VALUE     = 2'd0,
        REG_CENTER_WINDOW    = 2'd1,
        REG_CHANGE_THRESHOLD = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

// File: src/joystick_center_calib_normalize_core.sv
// A calibration transaction is absorbed by the offset registers and gives no result.
// A normalization transaction runs four serial divisions, one per axis, on the one
// shared bit-serial divider, each followed by a compare, then a finish step.
// Throughput: one transaction at a time; in_ready is high only while idle.
// Reset: offsets load center_value's reset value, history and calibration count clear.
`default_nettype none

module joystick_center_calib_normalize_core
    import jccn_pkg::*;
#(
    parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SAMPLE_BITS-1:0] raw_x1,
    input  wire logic [SAMPLE_BITS-1:0] raw_y1,
    input  wire logic                  press1,
    input  wire logic [SAMPLE_BITS-1:0] raw_x2,
    input  wire logic [SAMPLE_BITS-1:0] raw_y2,
    input  wire logic                  press2,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [AXIS_W-1:0]   axis_x1,
    output logic signed [AXIS_W-1:0]   axis_y1,
    output logic                       button1,
    output logic signed [AXIS_W-1:0]   axis_x2,
    output logic signed [AXIS_W-1:0]   axis_y2,
    output logic                       button2
);

    localparam int DIV_W = SAMPLE_BITS + NORM_SHIFT;
    localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
    localparam logic [AXIS_IDX_W-1:0] IDX_LAST = AXIS_IDX_W'(NUM_AXES - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t                     state_reg;
    logic [AXIS_IDX_W-1:0]      idx_reg;
    logic                       start_reg;
    logic                       emit_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic [OFF_W-1:0]           cv_reg;
    logic [OFF_W-1:0]           cw_reg;
    logic [THR_W-1:0]           thr_reg;
    logic [OFF_W-1:0]           off_reg   [NUM_AXES];

    logic [SAMPLE_BITS-1:0]     raw_reg   [NUM_AXES];
    logic [1:0]                 btn_reg;
    logic signed [AXIS_W-1:0]   axis_reg  [NUM_AXES];
    logic signed [AXIS_W-1:0]   prev_reg  [NUM_AXES];
    logic [1:0]                 prev_btn_reg;

    logic                       out_valid_reg;
    logic signed [AXIS_W-1:0]   out_axis_reg [NUM_AXES];
    logic [1:0]                 out_btn_reg;

    logic [SAMPLE_BITS-1:0]     in_raw    [NUM_AXES];
    logic [NUM_AXES-1:0]        in_win;
    logic signed [WIN_W-1:0]    win_lo;
    logic signed [WIN_W-1:0]    win_hi;
    logic                       cfg_fire;
    logic                       in_fire;
    logic                       calibrating;

    logic [DIV_W-1:0]           div_dividend;
    logic [OFF_W-1:0]           div_divisor;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quot;
    logic signed [AXIS_W-1:0]   axis_new;

    logic signed [AXIS_W:0]     axis_diff;
    logic [AXIS_W:0]            axis_mag;
    logic                       moved;
    logic                       emit_any;
    logic                       out_load;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign calibrating = (cnt_reg < CNT_W'(CALIB_SAMPLES));

    assign in_raw[0] = raw_x1;
    assign in_raw[1] = raw_y1;
    assign in_raw[2] = raw_x2;
    assign in_raw[3] = raw_y2;

    // Window bounds may go negative; compare signed
    always_comb
    begin
        win_lo = $signed(WIN_W'(cv_reg)) - $signed(WIN_W'(cw_reg));
        win_hi = $signed(WIN_W'(cv_reg)) + $signed(WIN_W'(cw_reg));
        for (int i = 0; i < NUM_AXES; i++)
        begin
            in_win[i] = ($signed(WIN_W'(in_raw[i])) >= win_lo) &&
                        ($signed(WIN_W'(in_raw[i])) <= win_hi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg  <= CENTER_RESET;
            cw_reg  <= WINDOW_RESET;
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_CENTER_VALUE:     cv_reg  <= cfg_data[OFF_W-1:0];
                REG_CENTER_WINDOW:    cw_reg  <= cfg_data[OFF_W-1:0];
                REG_CHANGE_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                off_reg[i] <= CENTER_RESET;
            end
            cnt_reg <= '0;
        end
        else
        begin
            // Reload offsets from a new center value only before calibration starts
            if (cfg_fire && (cfg_index == REG_CENTER_VALUE) && (cnt_reg == '0))
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    off_reg[i] <= cfg_data[OFF_W-1:0];
                end
            end
            else if (in_fire && calibrating)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    if (in_win[i])
                    begin
                        off_reg[i] <= OFF_W'(in_raw[i]);
                    end
                end
            end
            if (in_fire && calibrating)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign div_dividend = {raw_reg[idx_reg], {NORM_SHIFT{1'b0}}};
    assign div_divisor  = (off_reg[idx_reg] == '0) ? OFF_W'(1) : off_reg[idx_reg];

    jccn_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Saturate high only; the quotient is never negative
    assign axis_new = (div_quot > DIV_W'(SAT_Q_MAX)) ? AXIS_MAX
                                                     : AXIS_W'(div_quot - DIV_W'(NORM_BIAS));

    always_comb
    begin
        axis_diff = {axis_reg[idx_reg][AXIS_W-1], axis_reg[idx_reg]} -
                    {prev_reg[idx_reg][AXIS_W-1], prev_reg[idx_reg]};
        axis_mag  = axis_diff[AXIS_W] ? (AXIS_W + 1)'(-axis_diff) : axis_diff;
        moved     = (axis_mag > (AXIS_W + 1)'(thr_reg));
    end

    assign emit_any = emit_reg || (btn_reg != prev_btn_reg);
    assign out_load = (state_reg == S_FIN) && emit_any && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            start_reg     <= 1'b0;
            emit_reg      <= 1'b0;
            prev_btn_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            // Kick the divider for the first axis and after each compare but the last
            start_reg <= (in_fire && !calibrating) ||
                         ((state_reg == S_CMP) && (idx_reg != IDX_LAST));
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && !calibrating)
                    begin
                        idx_reg   <= '0;
                        emit_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    prev_reg[idx_reg] <= axis_reg[idx_reg];
                    if (moved)
                    begin
                        emit_reg <= 1'b1;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_DIV;
                    end
                end
                S_FIN:
                begin
                    // Hold while a result waits and the output is still full
                    if (!emit_any || out_load)
                    begin
                        prev_btn_reg <= btn_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                raw_reg[i] <= in_raw[i];
            end
            btn_reg <= {press2, press1};
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            axis_reg[idx_reg] <= axis_new;
        end
        if (out_load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                out_axis_reg[i] <= axis_reg[i];
            end
            out_btn_reg <= btn_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign axis_x1   = out_axis_reg[0];
    assign axis_y1   = out_axis_reg[1];
    assign axis_x2   = out_axis_reg[2];
    assign axis_y2   = out_axis_reg[3];
    assign button1   = out_btn_reg[0];
    assign button2   = out_btn_reg[1];

    a_calib_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && calibrating) |=> (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)))
        else $error("calibration count did not advance");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CALIB_SAMPLES))
        else $error("calibration count past its limit");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("division finished outside the divide state");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (idx_reg == IDX_LAST))
        else $error("finish reached before all axes were normalized");

endmodule

`default_nettype wire

// File: src/jccn_div.sv
// Radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module jccn_div
    import jccn_pkg::*;
#(
    parameter int DIV_W = SAMPLE_BITS_DEF + NORM_SHIFT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [OFF_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [OFF_W-1:0]     dsr_reg;
    logic [OFF_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dvd_reg;

    logic [OFF_W:0]       trial;
    logic                 fits;
    logic [OFF_W:0]       diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit, subtract when it fits
            rem_reg <= fits ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start) |-> (rem_reg < dsr_reg))
        else $error("partial remainder not below divisor");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

endmodule

`default_nettype wire
